FILE: rtl/core/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the sorted insert array.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(CAPACITY);

    typedef struct packed {
        logic [1:0]       command;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] count;
        logic [1:0]       status;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new input transaction
        logic compare;  // register the less-than mask
        logic commit;   // update the store and the result register
    } sia_cmd_t;

endpackage

FILE: rtl/core/sia_ctrl.sv
// ----------------------------------------------------------------------------
// sia_ctrl
// Sequencer: load, compare, commit; owns both handshakes.
// ----------------------------------------------------------------------------
module sia_ctrl
    import sia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output sia_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // commit only when the result register is free or being drained
    always_comb
    begin
        cmd.commit  = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);
        cmd.compare = (state_reg == S_COMPARE);
        in_ready    = (state_reg == S_IDLE) || cmd.commit;
        cmd.load    = in_valid && in_ready;
    end

    // next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (cmd.commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = cmd.load ? S_COMPARE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/sia_dp.sv
// ----------------------------------------------------------------------------
// sia_dp
// Datapath: sorted register array with parallel compare and shift,
// entry count, limit register and result register.
// ----------------------------------------------------------------------------
module sia_dp
    import sia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sia_cmd_t         cmd,
    input  in_item_t         in_data,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    output out_item_t        out_data
);

    in_item_t              item_reg;
    logic [CAPACITY-1:0]   lt_reg, lt_next;
    logic [VAL_W-1:0]      entries_reg [CAPACITY];
    logic [VAL_W-1:0]      entries_next [CAPACITY];
    logic [VAL_W-1:0]      entries_up [CAPACITY];
    logic [VAL_W-1:0]      entries_down [CAPACITY];
    logic [CAPACITY-1:0]   lt_prev;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      limit_reg;
    out_item_t             out_reg, out_next;
    logic                  full;
    logic                  idx_ok;

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    // less-than mask over the valid entries; a prefix since the array is sorted
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            lt_next[k] = (CNT_W'(k) < count_reg) && (entries_reg[k] < item_reg.value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            lt_reg <= lt_next;
        end
    end

    // neighbor views of the array for the shifts
    assign lt_prev = {lt_reg[CAPACITY-2:0], 1'b1};

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_nbr
        if (k == 0)
        begin : g_first
            assign entries_up[k] = '0;
        end
        else
        begin : g_up
            assign entries_up[k] = entries_reg[k-1];
        end
        if (k == CAPACITY - 1)
        begin : g_last
            assign entries_down[k] = entries_reg[k];
        end
        else
        begin : g_down
            assign entries_down[k] = entries_reg[k+1];
        end
    end

    assign full   = (count_reg >= limit_reg) || (count_reg >= CNT_W'(CAPACITY));
    assign idx_ok = {1'b0, item_reg.index} < count_reg;

    // apply the command to the store, the count and the result
    always_comb
    begin
        entries_next        = entries_reg;
        count_next          = count_reg;
        out_next.read_value = '0;
        out_next.status     = ST_OK;
        case (item_reg.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    out_next.status = ST_FULL;
                end
                else
                begin
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (!lt_reg[k])
                        begin
                            entries_next[k] = lt_prev[k] ? item_reg.value : entries_up[k];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                if (idx_ok)
                begin
                    out_next.read_value = entries_reg[item_reg.index];
                end
                else
                begin
                    out_next.status = ST_RANGE;
                end
            end
            CMD_REMOVE:
            begin
                if (idx_ok)
                begin
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (IDX_W'(k) >= item_reg.index)
                        begin
                            entries_next[k] = entries_down[k];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    out_next.status = ST_RANGE;
                end
            end
            default:
            begin
                out_next.status = ST_OK;
            end
        endcase
        out_next.count = count_next;
    end

    // entry storage and result register, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            entries_reg <= entries_next;
            out_reg     <= out_next;
        end
    end

    // count and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/core/sorted_insert_array_top.sv
// The compare register and the commit of the shifted array and the result are
// the two steps of each transaction; the commit waits while the output holds
// an undrained result, and a new input can be accepted as the previous commits.
// A finished result waits in the output register while the next one computes.
// Reset (rst_n, async, active low): count cleared, limit set to CAPACITY,
// entries left uninitialized and never read before written.
// ----------------------------------------------------------------------------
// sorted_insert_array_top
// Ascending list of up to CAPACITY 32-bit values with insert, lookup, remove.
// ----------------------------------------------------------------------------
module sorted_insert_array_top
    import sia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data
);

    sia_cmd_t cmd;

    // sequencer
    sia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // store and result
    sia_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_data    (out_data)
    );

    // count never exceeds the array size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.count <= CNT_W'(CAPACITY)))
        else $error("result count above capacity");

    // a nonzero read value only comes with ok status
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.read_value != '0)) |-> (out_data.status == ST_OK))
        else $error("read value with error status");

    // an accepted transaction blocks input for its compare cycle
    a_no_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted during compare");

    // status code is always a defined one
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                       out_data.status == ST_RANGE))
        else $error("undefined status code");

endmodule
